### rtl/core/sorted_table_bound_search_assert.svh
// Assertion macros shared by the sorted table bound search RTL.
`ifndef SORTED_TABLE_BOUND_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BOUND_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in this cycle implies consequent in the same cycle.
`define SBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle.
`define SBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBS_ASSERT(label, clk, rst_n, prop, msg)
`define SBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/sbs_pkg.sv
// Shared types and constants of the sorted table bound search block.
`default_nettype none

package sbs_pkg;

  // Field widths
  localparam int unsigned ModeW = 3;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned ValW  = 32;
  localparam int unsigned ResW  = 12;

  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Mode codes on the command port
  localparam logic [ModeW-1:0] MODE_WRITE    = 3'd0;
  localparam logic [ModeW-1:0] MODE_FIRST_GE = 3'd1;
  localparam logic [ModeW-1:0] MODE_LAST_LT  = 3'd2;
  localparam logic [ModeW-1:0] MODE_LAST_LE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_FIRST_GT = 3'd4;

  // Classified operation carried to the back end
  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_FIRST_GE = 3'd1,
    OP_LAST_LT  = 3'd2,
    OP_LAST_LE  = 3'd3,
    OP_FIRST_GT = 3'd4
  } op_e;

  // One queued item: lo is the write position for writes, value the write value or key
  typedef struct packed {
    op_e                    op;
    logic [IdxW-1:0]        lo;
    logic [IdxW-1:0]        hi;
    logic signed [ValW-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/sbs_front.sv
// Front end: decodes command items and holds them in a short queue.
`default_nettype none
`include "sorted_table_bound_search_assert.svh"

module sbs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [sbs_pkg::ModeW-1:0]     mode_i,
  input  wire logic [sbs_pkg::IdxW-1:0]      write_position_i,
  input  wire logic signed [sbs_pkg::ValW-1:0] write_value_i,
  input  wire logic [sbs_pkg::IdxW-1:0]      search_low_i,
  input  wire logic [sbs_pkg::IdxW-1:0]      search_high_i,
  input  wire logic signed [sbs_pkg::ValW-1:0] key_i,
  output logic                               head_valid_o,
  output sbs_pkg::entry_t                    head_o,
  input  wire logic                          pop_i
);

  localparam int unsigned PtrW = $clog2(sbs_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(sbs_pkg::QueueDepth + 1);

  sbs_pkg::entry_t       entry;
  logic                  entry_ok;
  logic                  push;
  sbs_pkg::entry_t       queue_q [sbs_pkg::QueueDepth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [CntW-1:0]       count_q, count_d;

  // Classify the incoming item; unused modes produce nothing
  always_comb begin
    entry       = '0;
    entry_ok    = 1'b1;
    entry.lo    = search_low_i;
    entry.hi    = search_high_i;
    entry.value = key_i;
    unique case (mode_i)
      sbs_pkg::MODE_WRITE: begin
        entry.op    = sbs_pkg::OP_WRITE;
        entry.lo    = write_position_i;
        entry.hi    = '0;
        entry.value = write_value_i;
      end
      sbs_pkg::MODE_FIRST_GE: entry.op = sbs_pkg::OP_FIRST_GE;
      sbs_pkg::MODE_LAST_LT:  entry.op = sbs_pkg::OP_LAST_LT;
      sbs_pkg::MODE_LAST_LE:  entry.op = sbs_pkg::OP_LAST_LE;
      sbs_pkg::MODE_FIRST_GT: entry.op = sbs_pkg::OP_FIRST_GT;
      default: entry_ok = 1'b0;
    endcase
  end

  assign busy_o = (count_q == CntW'(sbs_pkg::QueueDepth));
  assign push   = start_i && !busy_o && entry_ok;

  // Occupancy and pointers
  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= entry;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rptr_q];

  `SBS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(sbs_pkg::QueueDepth),
              "queue count beyond depth")
  `SBS_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0,
                  "pop from empty queue")
  `SBS_ASSERT_NXT(a_push_counts, clk_i, rst_ni, push && !pop_i,
                  count_q == $past(count_q) + CntW'(1), "push not counted")

endmodule

`default_nettype wire

### rtl/core/sbs_back.sv
// Back end: table memory and the binary search engine, one probe per cycle.
`default_nettype none
`include "sorted_table_bound_search_assert.svh"

module sbs_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         head_valid_i,
  input  wire sbs_pkg::entry_t              head_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic signed [sbs_pkg::ResW-1:0]   bound_index_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned IdxW  = sbs_pkg::IdxW;
  localparam int unsigned ValW  = sbs_pkg::ValW;
  localparam int unsigned ResW  = sbs_pkg::ResW;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  sbs_pkg::op_e            op_q, op_d;
  logic [IdxW-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [ValW-1:0]  key_q, key_d;
  logic signed [ValW-1:0]  rdata_q, probe_val;
  logic                    inr_q;
  logic                    run, more, upper_d, wr_en, rd_en;
  logic [IdxW:0]           mid_sum;
  logic signed [ResW-1:0]  res_d, res_q;
  logic                    res_valid_q;
  logic signed [ValW-1:0]  mem_q [TABLE_DEPTH];

  // Probes outside the table read as zero
  assign probe_val = inr_q ? rdata_q : '0;
  assign pop_o     = (state_q == ST_IDLE) && head_valid_i;

  // Next window, next probe and result
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    key_d   = key_q;
    run     = 1'b0;
    wr_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (head_i.op == sbs_pkg::OP_WRITE) begin
            wr_en = (32'(head_i.lo) < TABLE_DEPTH);
          end else begin
            run   = 1'b1;
            op_d  = head_i.op;
            lo_d  = head_i.lo;
            hi_d  = head_i.hi;
            key_d = head_i.value;
          end
        end
      end
      ST_SEARCH: begin
        run = 1'b1;
        if (op_q == sbs_pkg::OP_LAST_LE || op_q == sbs_pkg::OP_FIRST_GT) begin
          // last entry <= key: keep mid on the low side
          if (key_q >= probe_val) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q - IdxW'(1);
          end
        end else begin
          // first entry >= key: keep mid on the high side
          if (key_q <= probe_val) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q + IdxW'(1);
          end
        end
      end
      default: ;
    endcase

    upper_d = (op_d == sbs_pkg::OP_LAST_LE) || (op_d == sbs_pkg::OP_FIRST_GT);
    mid_sum = (IdxW+1)'(lo_d) + (IdxW+1)'(hi_d) + (IdxW+1)'(upper_d);
    mid_d   = mid_sum[IdxW:1];
    more    = (lo_d < hi_d);
    rd_en   = run && more;
    if (run) begin
      state_d = more ? ST_SEARCH : ST_IDLE;
    end

    // Bound adjustment for the off-by-one modes
    res_d = ResW'(lo_d);
    if (op_d == sbs_pkg::OP_LAST_LT) begin
      res_d = ResW'(lo_d) - ResW'(1);
    end else if (op_d == sbs_pkg::OP_FIRST_GT) begin
      res_d = ResW'(lo_d) + ResW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= run && !more;
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    key_q <= key_d;
    if (rd_en) begin
      mid_q <= mid_d;
      inr_q <= (32'(mid_d) < TABLE_DEPTH);
    end
    if (run && !more) begin
      res_q <= res_d;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(head_i.lo)] <= head_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[AddrW'(mid_d)];
    end
  end

  assign result_valid_o = res_valid_q;
  assign bound_index_o  = res_q;

  `SBS_ASSERT_IMP(a_search_window, clk_i, rst_ni, state_q == ST_SEARCH, lo_q < hi_q,
                  "search running on an empty window")
  `SBS_ASSERT_IMP(a_mid_inside, clk_i, rst_ni, state_q == ST_SEARCH,
                  mid_q >= lo_q && mid_q <= hi_q, "probe outside the window")
  `SBS_ASSERT_NXT(a_window_shrinks, clk_i, rst_ni, state_q == ST_SEARCH,
                  state_q == ST_IDLE || (hi_q - lo_q) < $past(hi_q - lo_q),
                  "search window did not shrink")

endmodule

`default_nettype wire

### rtl/core/sorted_table_bound_search.sv
// Top level of the sorted table bound search block.
// Usage:
//   Command channel: an item is taken at a clock edge where start_i is high and
//   busy_o is low. mode_i selects a table write (position and value) or one of
//   four bound queries over the window search_low_i..search_high_i for key_i.
//   Unused modes are taken and dropped.
//   Result channel: each query gives one bound_index_o, shown for exactly one
//   cycle with result_valid_o high; the receiver must take it then.
// Timing:
//   A two-item queue sits between the command decoder and the search engine.
//   The engine takes one item at a time; a write needs no probes and a query
//   takes P = ceil(log2(window size)) probes, one table memory read per cycle;
//   at most 10 probes for a full window.
//   A query goes from the queue through the probes to the result register.
//   busy_o is high while the queue is full.
// Reset: clears the queue and the engine; table contents are undefined
//   until written, and there is no clearing pass.
`default_nettype none

module sorted_table_bound_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [sbs_pkg::ModeW-1:0]       mode_i,
  input  wire logic [sbs_pkg::IdxW-1:0]        write_position_i,
  input  wire logic signed [sbs_pkg::ValW-1:0] write_value_i,
  input  wire logic [sbs_pkg::IdxW-1:0]        search_low_i,
  input  wire logic [sbs_pkg::IdxW-1:0]        search_high_i,
  input  wire logic signed [sbs_pkg::ValW-1:0] key_i,
  output logic                                 result_valid_o,
  output logic signed [sbs_pkg::ResW-1:0]      bound_index_o
);

  logic            head_valid;
  sbs_pkg::entry_t head;
  logic            pop;

  // Decode and queue
  sbs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .write_position_i (write_position_i),
    .write_value_i    (write_value_i),
    .search_low_i     (search_low_i),
    .search_high_i    (search_high_i),
    .key_i            (key_i),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  // Table and search engine
  sbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .bound_index_o  (bound_index_o)
  );

endmodule

`default_nettype wire
